>>> design/mvd_pkg.sv
package mvd_pkg;

    localparam int VOXEL_W = 32;
    localparam int DIM_W   = 16;
    localparam int LCNT_W  = 4;
    localparam int RED_W   = 4;
    localparam int RATE_W  = 5;
    localparam int LEVEL_W = 4;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_DIM_X      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DIM_Y      = 3'd1;
    localparam logic [ADDR_W-1:0] REG_DIM_Z      = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LEVEL_CNT  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_REDUCTIONS = 3'd4;
    localparam logic [ADDR_W-1:0] REG_RATE       = 3'd5;

    typedef struct packed {
        logic [DIM_W-1:0]  dim_x;
        logic [DIM_W-1:0]  dim_y;
        logic [DIM_W-1:0]  dim_z;
        logic [RED_W-1:0]  reductions;
        logic [RATE_W-1:0] rate;
    } t_derive_cfg;

    typedef struct packed {
        logic done;
        logic wr_en;
    } t_derive_sts;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        return (d == '0) ? DIM_W'(1) : d;
    endfunction

endpackage

>>> design/mvd_stride_unit.sv
module mvd_stride_unit #(
    parameter int MAX_LEVELS  = 8,
    parameter int COORD_WIDTH = 16,
    localparam int SW     = COORD_WIDTH + 1,
    localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mvd_pkg::t_derive_cfg i_cfg,
    output mvd_pkg::t_derive_sts o_sts,
    output logic [LIDX_W-1:0]    o_wr_level,
    output logic [SW-1:0]        o_x_stride,
    output logic [SW-1:0]        o_y_stride,
    output logic [SW-1:0]        o_z_stride
);
    import mvd_pkg::*;

    localparam int PW    = SW + RATE_W;
    localparam int CNT_W = $clog2(DIM_W);
    localparam logic [PW-1:0] CAP = {{(PW-SW){1'b0}}, 1'b1, {COORD_WIDTH{1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_STEP, S_DIV, S_FIN, S_DONE} t_state;
    typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} t_axis;

    t_state              r_state;
    t_axis               r_axis;
    logic [DIM_W-1:0]    r_dx, r_dy, r_dz;
    logic [SW-1:0]       r_sx, r_sy, r_sz;
    logic [RATE_W-1:0]   r_rate;
    logic [RED_W-1:0]    r_red;
    logic [LIDX_W-1:0]   r_lvl;
    logic [DIM_W-1:0]    r_quo;
    logic [RATE_W-1:0]   r_rem;
    logic [CNT_W-1:0]    r_cnt;

    t_axis               n_axis;
    logic [SW-1:0]       sel_stride;
    logic [PW-1:0]       prod;
    logic [SW-1:0]       grown;
    logic [DIM_W-1:0]    sel_dim;
    logic [RATE_W:0]     rem_sh;
    logic                ge;
    logic [RATE_W:0]     rem_nx;
    logic [DIM_W-1:0]    shrunk;
    logic                more;

    assign more = (r_red < i_cfg.reductions);

    always_comb begin
        if (r_dz >= r_dy && r_dz >= r_dx) begin
            n_axis = AXIS_Z;
        end else if (r_dy >= r_dx) begin
            n_axis = AXIS_Y;
        end else begin
            n_axis = AXIS_X;
        end
        unique case (n_axis)
            AXIS_X: begin
                sel_stride = r_sx;
                sel_dim    = r_dx;
            end
            AXIS_Y: begin
                sel_stride = r_sy;
                sel_dim    = r_dy;
            end
            default: begin
                sel_stride = r_sz;
                sel_dim    = r_dz;
            end
        endcase
        prod   = PW'(sel_stride) * PW'(r_rate);
        grown  = (prod > CAP) ? SW'(CAP) : SW'(prod);
        rem_sh = {r_rem, r_quo[DIM_W-1]};
        ge     = (rem_sh >= {1'b0, r_rate});
        rem_nx = ge ? (rem_sh - {1'b0, r_rate}) : rem_sh;
        shrunk = r_quo + ((r_rem != '0) ? DIM_W'(1) : DIM_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_red   <= '0;
            r_lvl   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dx    <= eff_dim(i_cfg.dim_x);
                        r_dy    <= eff_dim(i_cfg.dim_y);
                        r_dz    <= eff_dim(i_cfg.dim_z);
                        r_sx    <= SW'(1);
                        r_sy    <= SW'(1);
                        r_sz    <= SW'(1);
                        r_rate  <= (i_cfg.rate == '0) ? RATE_W'(1) : i_cfg.rate;
                        r_red   <= '0;
                        r_lvl   <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (more) begin
                        r_axis <= n_axis;
                        unique case (n_axis)
                            AXIS_X:  r_sx <= grown;
                            AXIS_Y:  r_sy <= grown;
                            default: r_sz <= grown;
                        endcase
                        r_quo   <= sel_dim;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (r_lvl == LIDX_W'(MAX_LEVELS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                        r_red <= '0;
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[DIM_W-2:0], ge};
                    r_rem <= RATE_W'(rem_nx);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIM_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    unique case (r_axis)
                        AXIS_X:  r_dx <= shrunk;
                        AXIS_Y:  r_dy <= shrunk;
                        default: r_dz <= shrunk;
                    endcase
                    r_red   <= r_red + 1'b1;
                    r_state <= S_STEP;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.wr_en = (r_state == S_STEP) && !more;
    assign o_wr_level  = r_lvl;
    assign o_x_stride  = r_sx;
    assign o_y_stride  = r_sy;
    assign o_z_stride  = r_sz;

endmodule

>>> design/multilevel_volume_decimator.sv
// Voxel that does not open a volume: accepted, then results follow one per cycle
// from the next cycle on while the receiver is ready; no voxel is taken meanwhile.
// Voxel that opens a volume: the stride sequencer and its bit-serial divider run
// first, then its results follow in the same way.
// Synchronous active-low reset clears counters, phases and control and loads the
// config defaults; strides are rebuilt for the first voxel after reset, before it is used.
module multilevel_volume_decimator #(
    parameter int MAX_LEVELS  = 8,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mvd_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  logic [mvd_pkg::DIM_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mvd_pkg::VOXEL_W-1:0]   s_axis_tdata,   // [31:0] voxel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mvd_pkg::VOXEL_W-1:0]   m_axis_tdata,   // [31:0] value
    output logic [mvd_pkg::LEVEL_W-1:0]   m_axis_tuser,   // [3:0] level
    output logic                          m_axis_tlast
);
    import mvd_pkg::*;

    localparam int SW     = COORD_WIDTH + 1;
    localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CMP_W  = (COORD_WIDTH + 1 > DIM_W) ? COORD_WIDTH + 1 : DIM_W;

    typedef enum logic [1:0] {ST_IDLE, ST_DERIVE, ST_EMIT} t_state;

    t_state                 r_state;
    logic [DIM_W-1:0]       r_dim_x, r_dim_y, r_dim_z;
    logic [LCNT_W-1:0]      r_level_count;
    logic [RED_W-1:0]       r_reductions;
    logic [RATE_W-1:0]      r_rate;
    logic [COORD_WIDTH-1:0] r_col, r_row, r_slice;
    logic [SW-1:0]          r_xph [MAX_LEVELS];
    logic [SW-1:0]          r_yph [MAX_LEVELS];
    logic [SW-1:0]          r_zph [MAX_LEVELS];
    logic [SW-1:0]          r_xs  [MAX_LEVELS];
    logic [SW-1:0]          r_ys  [MAX_LEVELS];
    logic [SW-1:0]          r_zs  [MAX_LEVELS];
    logic [VOXEL_W-1:0]     r_voxel;
    logic [MAX_LEVELS-1:0]  r_mask;

    logic [SW-1:0]          n_xph [MAX_LEVELS];
    logic [SW-1:0]          n_yph [MAX_LEVELS];
    logic [SW-1:0]          n_zph [MAX_LEVELS];
    logic [COORD_WIDTH-1:0] n_col, n_row, n_slice;
    logic [MAX_LEVELS-1:0]  n_mask;

    t_derive_cfg            derive_cfg;
    t_derive_sts            derive_sts;
    logic [LIDX_W-1:0]      wr_level;
    logic [SW-1:0]          wr_xs, wr_ys, wr_zs;

    logic                   in_fire, out_fire, vol_start, do_update;
    logic [COORD_WIDTH:0]   col_p1, row_p1, slice_p1;
    logic                   col_wrap, row_wrap, slice_wrap;
    logic [LCNT_W:0]        lc_sat;
    logic [LIDX_W-1:0]      low_idx;
    logic [LIDX_W:0]        lvl_sum;
    logic [MAX_LEVELS-1:0]  mask_rest;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign vol_start     = (r_col == '0) && (r_row == '0) && (r_slice == '0);
    assign do_update     = (in_fire && !vol_start)
                         || ((r_state == ST_DERIVE) && derive_sts.done);

    assign derive_cfg.dim_x      = r_dim_x;
    assign derive_cfg.dim_y      = r_dim_y;
    assign derive_cfg.dim_z      = r_dim_z;
    assign derive_cfg.reductions = r_reductions;
    assign derive_cfg.rate       = r_rate;

    mvd_stride_unit #(
        .MAX_LEVELS  (MAX_LEVELS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_stride (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire && vol_start),
        .i_cfg      (derive_cfg),
        .o_sts      (derive_sts),
        .o_wr_level (wr_level),
        .o_x_stride (wr_xs),
        .o_y_stride (wr_ys),
        .o_z_stride (wr_zs)
    );

    always_comb begin
        col_p1     = {1'b0, r_col} + 1'b1;
        row_p1     = {1'b0, r_row} + 1'b1;
        slice_p1   = {1'b0, r_slice} + 1'b1;
        col_wrap   = (col_p1[COORD_WIDTH-1:0] == '0)
                   || (CMP_W'(col_p1) >= CMP_W'(eff_dim(r_dim_x)));
        row_wrap   = col_wrap && ((row_p1[COORD_WIDTH-1:0] == '0)
                   || (CMP_W'(row_p1) >= CMP_W'(eff_dim(r_dim_y))));
        slice_wrap = row_wrap && ((slice_p1[COORD_WIDTH-1:0] == '0)
                   || (CMP_W'(slice_p1) >= CMP_W'(eff_dim(r_dim_z))));
        n_col   = col_wrap ? '0 : col_p1[COORD_WIDTH-1:0];
        n_row   = col_wrap ? (row_wrap ? '0 : row_p1[COORD_WIDTH-1:0]) : r_row;
        n_slice = row_wrap ? (slice_wrap ? '0 : slice_p1[COORD_WIDTH-1:0]) : r_slice;

        lc_sat = ({1'b0, r_level_count} > (LCNT_W+1)'(MAX_LEVELS))
               ? (LCNT_W+1)'(MAX_LEVELS) : {1'b0, r_level_count};

        for (int l = 0; l < MAX_LEVELS; l++) begin
            n_mask[l] = ((LCNT_W+1)'(l) < lc_sat) && (r_xph[l] == '0)
                      && (r_yph[l] == '0) && (r_zph[l] == '0);
            n_xph[l] = (col_wrap || (r_xph[l] + SW'(1) >= r_xs[l]))
                     ? '0 : r_xph[l] + SW'(1);
            if (col_wrap) begin
                n_yph[l] = (row_wrap || (r_yph[l] + SW'(1) >= r_ys[l]))
                         ? '0 : r_yph[l] + SW'(1);
            end else begin
                n_yph[l] = r_yph[l];
            end
            if (row_wrap) begin
                n_zph[l] = (slice_wrap || (r_zph[l] + SW'(1) >= r_zs[l]))
                         ? '0 : r_zph[l] + SW'(1);
            end else begin
                n_zph[l] = r_zph[l];
            end
        end

        low_idx = '0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
            if (r_mask[l]) begin
                low_idx = LIDX_W'(l);
            end
        end
        lvl_sum   = {1'b0, low_idx} + 1'b1;
        mask_rest = r_mask & (r_mask - 1'b1);
    end

    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = r_voxel;
    assign m_axis_tuser  = LEVEL_W'(lvl_sum);
    assign m_axis_tlast  = (mask_rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_dim_x       <= DIM_W'(1);
            r_dim_y       <= DIM_W'(1);
            r_dim_z       <= DIM_W'(1);
            r_level_count <= LCNT_W'(1);
            r_reductions  <= RED_W'(1);
            r_rate        <= RATE_W'(2);
            r_col         <= '0;
            r_row         <= '0;
            r_slice       <= '0;
            r_mask        <= '0;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_xph[l] <= '0;
                r_yph[l] <= '0;
                r_zph[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_DIM_X:      r_dim_x       <= i_cfg_wdata;
                    REG_DIM_Y:      r_dim_y       <= i_cfg_wdata;
                    REG_DIM_Z:      r_dim_z       <= i_cfg_wdata;
                    REG_LEVEL_CNT:  r_level_count <= i_cfg_wdata[LCNT_W-1:0];
                    REG_REDUCTIONS: r_reductions  <= i_cfg_wdata[RED_W-1:0];
                    REG_RATE:       r_rate        <= i_cfg_wdata[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (do_update) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_slice <= n_slice;
                r_mask  <= n_mask;
                r_state <= (n_mask != '0) ? ST_EMIT : ST_IDLE;
                for (int l = 0; l < MAX_LEVELS; l++) begin
                    r_xph[l] <= n_xph[l];
                    r_yph[l] <= n_yph[l];
                    r_zph[l] <= n_zph[l];
                end
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (in_fire) begin
                            r_state <= ST_DERIVE;
                            for (int l = 0; l < MAX_LEVELS; l++) begin
                                r_xph[l] <= '0;
                                r_yph[l] <= '0;
                                r_zph[l] <= '0;
                            end
                        end
                    end
                    ST_DERIVE: ;
                    ST_EMIT: begin
                        if (out_fire) begin
                            r_mask <= mask_rest;
                            if (mask_rest == '0) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_voxel <= s_axis_tdata;
        end
        if (derive_sts.wr_en) begin
            r_xs[wr_level] <= wr_xs;
            r_ys[wr_level] <= wr_ys;
            r_zs[wr_level] <= wr_zs;
        end
    end

endmodule

>>> test/mvd_result_checker.sv
`timescale 1ns / 100ps

module mvd_result_checker
    import mvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [DIM_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [VOXEL_W-1:0] i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [VOXEL_W-1:0] i_out_data,
    input  logic [LEVEL_W-1:0] i_out_level,
    input  logic               i_out_last,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int          LEVELS     = 8;
    localparam int unsigned STRIDE_CAP = 32'd65536;
    localparam int          SHOW_LIMIT = 10;

    typedef struct packed {
        logic [VOXEL_W-1:0] value;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_kept_voxel;

    t_kept_voxel expected_kept[$];
    t_kept_voxel want;

    logic [DIM_W-1:0]  dim_x, dim_y, dim_z;
    logic [LCNT_W-1:0] level_cnt;
    logic [RED_W-1:0]  reductions;
    logic [RATE_W-1:0] rate;
    logic [DIM_W-1:0]  col, row, slc;
    logic [16:0]       x_stride [LEVELS];
    logic [16:0]       y_stride [LEVELS];
    logic [16:0]       z_stride [LEVELS];
    logic [16:0]       x_phase  [LEVELS];
    logic [16:0]       y_phase  [LEVELS];
    logic [16:0]       z_phase  [LEVELS];

    function automatic int unsigned at_least_one(int unsigned d);
        return (d == 0) ? 1 : d;
    endfunction

    function automatic logic [16:0] step_phase(logic [16:0] p, logic [16:0] s);
        return (int'(p) + 1 >= int'(s)) ? 17'd0 : p + 17'd1;
    endfunction

    task automatic rebuild_strides();
        int unsigned r, dx, dy, dz, sx, sy, sz;
        r  = at_least_one(rate);
        dx = at_least_one(dim_x);
        dy = at_least_one(dim_y);
        dz = at_least_one(dim_z);
        sx = 1;
        sy = 1;
        sz = 1;
        for (int lv = 0; lv < LEVELS; lv++) begin
            for (int k = 0; k < reductions; k++) begin
                if (dz >= dy && dz >= dx) begin
                    sz = (sz * r > STRIDE_CAP) ? STRIDE_CAP : sz * r;
                    dz = (dz + r - 1) / r;
                end else if (dy >= dx) begin
                    sy = (sy * r > STRIDE_CAP) ? STRIDE_CAP : sy * r;
                    dy = (dy + r - 1) / r;
                end else begin
                    sx = (sx * r > STRIDE_CAP) ? STRIDE_CAP : sx * r;
                    dx = (dx + r - 1) / r;
                end
            end
            x_stride[lv] = 17'(sx);
            y_stride[lv] = 17'(sy);
            z_stride[lv] = 17'(sz);
            x_phase[lv]  = '0;
            y_phase[lv]  = '0;
            z_phase[lv]  = '0;
        end
    endtask

    task automatic clear_model();
        dim_x      = 16'd1;
        dim_y      = 16'd1;
        dim_z      = 16'd1;
        level_cnt  = 4'd1;
        reductions = 4'd1;
        rate       = 5'd2;
        col        = '0;
        row        = '0;
        slc        = '0;
        expected_kept.delete();
        rebuild_strides();
    endtask

    task automatic predict_kept_levels(input logic [VOXEL_W-1:0] voxel);
        int unsigned levels;
        int          n;
        logic        col_wrap, row_wrap, slc_wrap;
        if (col == '0 && row == '0 && slc == '0) begin
            rebuild_strides();
        end
        levels = (level_cnt > LEVELS) ? LEVELS : level_cnt;
        n = 0;
        for (int lv = 0; lv < levels; lv++) begin
            if (x_phase[lv] == '0 && y_phase[lv] == '0 && z_phase[lv] == '0) begin
                expected_kept.push_back('{voxel, LEVEL_W'(lv + 1), 1'b0});
                n++;
            end
        end
        if (n > 0) begin
            expected_kept[expected_kept.size() - 1].last = 1'b1;
        end

        col_wrap = (col == '1) || (int'(col) + 1 >= int'(at_least_one(dim_x)));
        row_wrap = col_wrap && ((row == '1) || (int'(row) + 1 >= int'(at_least_one(dim_y))));
        slc_wrap = row_wrap && ((slc == '1) || (int'(slc) + 1 >= int'(at_least_one(dim_z))));

        col = col_wrap ? '0 : col + 1'b1;
        if (col_wrap) begin
            row = row_wrap ? '0 : row + 1'b1;
        end
        if (row_wrap) begin
            slc = slc_wrap ? '0 : slc + 1'b1;
        end
        for (int lv = 0; lv < LEVELS; lv++) begin
            x_phase[lv] = col_wrap ? '0 : step_phase(x_phase[lv], x_stride[lv]);
            if (col_wrap) begin
                y_phase[lv] = row_wrap ? '0 : step_phase(y_phase[lv], y_stride[lv]);
            end
            if (row_wrap) begin
                z_phase[lv] = slc_wrap ? '0 : step_phase(z_phase[lv], z_stride[lv]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_DIM_X:      dim_x      = i_cfg_wdata;
                    REG_DIM_Y:      dim_y      = i_cfg_wdata;
                    REG_DIM_Z:      dim_z      = i_cfg_wdata;
                    REG_LEVEL_CNT:  level_cnt  = i_cfg_wdata[LCNT_W-1:0];
                    REG_REDUCTIONS: reductions = i_cfg_wdata[RED_W-1:0];
                    REG_RATE:       rate       = i_cfg_wdata[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_kept_levels(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_kept.size() == 0) begin
                    if (o_errors < SHOW_LIMIT) begin
                        $display("unexpected transaction: value %h level %0d last %b",
                                 i_out_data, i_out_level, i_out_last);
                    end
                    o_errors++;
                end else begin
                    want = expected_kept.pop_front();
                    if (want.value !== i_out_data || want.level !== i_out_level ||
                        want.last !== i_out_last) begin
                        if (o_errors < SHOW_LIMIT) begin
                            $display({"mismatch: expected value %h level %0d last %b, ",
                                      "got value %h level %0d last %b"},
                                     want.value, want.level, want.last,
                                     i_out_data, i_out_level, i_out_last);
                        end
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_kept.size();
    end

endmodule

>>> test/multilevel_volume_decimator_test.sv
`timescale 1ns / 100ps

module multilevel_volume_decimator_test;
    import mvd_pkg::*;

    localparam int SETTLE_CYCLES = 2500;
    localparam int RANDOM_ITEMS  = 310;
    localparam int LONG_HOLD     = 400;

    localparam logic [ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ADDR_W-1:0] REG_SPARE_B = 3'd7;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [DIM_W-1:0]   i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VOXEL_W-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VOXEL_W-1:0] m_axis_tdata;
    logic [LEVEL_W-1:0] m_axis_tuser;
    logic               m_axis_tlast;

    int   errors;
    int   pending;
    int   voxels_sent = 0;
    logic tx_idle     = 1'b1;
    logic rx_idle     = 1'b1;
    logic rx_hold_req = 1'b0;

    multilevel_volume_decimator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    mvd_result_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_level (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("multilevel_volume_decimator verification failed");
        $finish;
    end

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_idle ? $urandom_range(0, 11) : 0;
            if (rx_hold_req) begin
                gap = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [VOXEL_W-1:0] pick_voxel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        return ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
    endfunction

    task automatic send_voxel(input logic [VOXEL_W-1:0] voxel);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= voxel;
        do @(posedge i_clk); while (!s_axis_tready);
        voxels_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_voxel(pick_voxel());
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DIM_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [DIM_W-1:0] dx, input logic [DIM_W-1:0] dy,
                             input logic [DIM_W-1:0] dz, input logic [DIM_W-1:0] levels,
                             input logic [DIM_W-1:0] reds, input logic [DIM_W-1:0] factor);
        write_reg(REG_DIM_X, dx);
        write_reg(REG_DIM_Y, dy);
        write_reg(REG_DIM_Z, dz);
        write_reg(REG_LEVEL_CNT, levels);
        write_reg(REG_REDUCTIONS, reds);
        write_reg(REG_RATE, factor);
    endtask

    initial begin
        logic [DIM_W-1:0] dx, dy, dz, levels, reds, factor;
        int unsigned      vol;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, one volume per voxel
        send_voxel(32'h0000_0000);
        send_voxel(32'hFFFF_FFFF);
        send_voxel(32'hAAAA_AAAA);
        send_voxel(32'h5555_5555);
        drain();

        // zero dimensions, zero levels
        configure(16'd0, 16'd0, 16'd0, 16'hFFF0, 16'd1, 16'd2);
        send_random(2);
        drain();

        // zero rate, level count above the maximum
        configure(16'd3, 16'd2, 16'd2, 16'd15, 16'd1, 16'hFFE0);
        send_random(4);
        drain();

        // change dimensions mid-volume
        configure(16'd2, 16'hFFFF, 16'hFFFF, 16'd8, 16'd8, 16'd16);
        send_random(4);
        drain();

        // collapse the volume so the voxel after this one opens a new one
        configure(16'd1, 16'd1, 16'd1, 16'd8, 16'd8, 16'd16);
        write_reg(REG_SPARE_A, 16'($urandom()));
        write_reg(REG_SPARE_B, 16'($urandom()));
        send_random(1);
        drain();

        // saturated strides
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8, 16'd15, 16'd31);
        send_random(4);
        drain();

        // fill the block while the receiver holds off
        configure(16'd1, 16'd1, 16'd1, 16'd8, 16'd0, 16'd1);
        send_random(1);
        drain();
        configure(16'd4, 16'd2, 16'd2, 16'd8, 16'd0, 16'd1);
        tx_idle     = 1'b0;
        rx_hold_req = 1'b1;
        send_random(16);
        drain();

        while (voxels_sent < RANDOM_ITEMS) begin
            dx     = pick_dim();
            dy     = pick_dim();
            dz     = pick_dim();
            levels = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 15))
                                                 : 16'($urandom_range(1, 8));
            reds   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 15))
                                                 : 16'($urandom_range(0, 4));
            factor = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 31))
                                                 : 16'($urandom_range(1, 4));
            levels = levels | (16'($urandom()) & 16'hFFF0);
            reds   = reds   | (16'($urandom()) & 16'hFFF0);
            factor = factor | (16'($urandom()) & 16'hFFE0);
            configure(dx, dy, dz, levels, reds, factor);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            vol = ((dx == 0) ? 1 : dx) * ((dy == 0) ? 1 : dy) * ((dz == 0) ? 1 : dz);
            if ($urandom_range(0, 3) == 0) begin
                send_random($urandom_range(1, vol));
            end else begin
                send_random(vol * $urandom_range(1, 2));
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("multilevel_volume_decimator verification clean");
        end else begin
            $display("multilevel_volume_decimator verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/mvd_pkg.sv
design/mvd_stride_unit.sv
design/multilevel_volume_decimator.sv
test/mvd_result_checker.sv
test/multilevel_volume_decimator_test.sv
